@@ rtl/bgas_pkg.sv @@
package bgas_pkg;

    localparam int GRID_COLS = 128;
    localparam int GRID_ROWS = 128;

    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);
    // step counter runs from 0 to GRID_ROWS + 1
    localparam int CNT_W = $clog2(GRID_ROWS + 2);

    localparam int OP_W     = 2;
    localparam int COL_IN_W = 7;
    localparam int ROW_IN_W = 7;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
    } t_mem_req;

endpackage

@@ rtl/bgas_row_mem.sv @@
module bgas_row_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bgas_pkg::t_mem_req            i_req,
    input  logic [bgas_pkg::GRID_COLS-1:0] i_wr_row,
    output logic [bgas_pkg::GRID_COLS-1:0] o_rd_row
);
    import bgas_pkg::*;

    logic [GRID_COLS-1:0] r_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_valid;
    logic [GRID_COLS-1:0] r_rd_row;
    logic                 r_rd_ok;

    // rows never written since reset read as all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_row;
        end
        if (i_req.rd_en) begin
            r_rd_row <= r_mem[i_req.rd_addr];
            r_rd_ok  <= r_valid[i_req.rd_addr];
        end
    end

    assign o_rd_row = r_rd_ok ? r_rd_row : '0;

endmodule

@@ rtl/bgas_row_unit.sv @@
module bgas_row_unit (
    input  logic [bgas_pkg::GRID_COLS-1:0] i_north,
    input  logic [bgas_pkg::GRID_COLS-1:0] i_center,
    input  logic [bgas_pkg::GRID_COLS-1:0] i_south,
    output logic [bgas_pkg::GRID_COLS-1:0] o_row
);
    import bgas_pkg::*;

    logic [GRID_COLS-1:0] w_east;
    logic [GRID_COLS-1:0] w_west;

    // bit c holds column c
    assign w_east = i_center >> 1;
    assign w_west = i_center << 1;
    assign o_row  = (w_east | w_west | i_north) & ~(w_east & i_south & i_north);

endmodule

@@ rtl/binary_grid_automaton_step.sv @@
// Cell read: row read; cell write: row read, then modified and written back; step: one
// row per cycle through the single read and single write port of the row memory; unused
// opcode or off-grid cell access: result registered at the accepting edge.
// One command at a time; the next beat is taken in the cycle after the result beat at the
// earliest.
// Synchronous active-low reset clears the grid at once through per-row valid flags.
module binary_grid_automaton_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bgas_pkg::S_DATA_W-1:0] i_s_tdata,   // col[6:0], row[13:7], write_value[14]
    input  logic [bgas_pkg::OP_W-1:0]     i_s_tuser,   // opcode[1:0]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bgas_pkg::M_DATA_W-1:0] o_m_tdata,   // read_value[0]
    output logic [bgas_pkg::OP_W-1:0]     o_m_tuser    // done_kind[1:0]
);
    import bgas_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CELL,
        S_STEP
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt;
    t_op                  r_op;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic                 r_wv;
    logic [GRID_COLS-1:0] r_north;
    logic [GRID_COLS-1:0] r_center;
    logic                 r_out_valid;
    t_op                  r_out_kind;
    logic                 r_out_val;

    t_op                  w_in_op;
    logic [COL_IN_W-1:0]  w_in_col;
    logic [ROW_IN_W-1:0]  w_in_row;
    logic                 w_in_wv;
    logic                 w_in_inside;
    logic                 w_accept;
    logic [GRID_COLS-1:0] w_rd_row;
    logic [GRID_COLS-1:0] w_south;
    logic [GRID_COLS-1:0] w_new_row;
    logic [GRID_COLS-1:0] w_cell_row;
    logic [GRID_COLS-1:0] w_wr_row;
    logic [CNT_W-1:0]     w_wr_cnt;
    t_mem_req             w_req;

    assign w_in_op     = t_op'(i_s_tuser);
    assign w_in_col    = i_s_tdata[COL_IN_W-1:0];
    assign w_in_row    = i_s_tdata[COL_IN_W +: ROW_IN_W];
    assign w_in_wv     = i_s_tdata[COL_IN_W + ROW_IN_W];
    assign w_in_inside = (int'(w_in_row) < GRID_ROWS) && (int'(w_in_col) < GRID_COLS);

    assign o_s_tready = (r_state == S_IDLE) && !r_out_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // rows below the grid are dead
    assign w_south  = (r_cnt <= CNT_W'(GRID_ROWS)) ? w_rd_row : '0;
    assign w_wr_cnt = r_cnt - CNT_W'(2);

    always_comb begin
        w_cell_row        = w_rd_row;
        w_cell_row[r_col] = r_wv;
    end

    assign w_wr_row = (r_state == S_STEP) ? w_new_row : w_cell_row;

    always_comb begin
        w_req = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_in_inside && (w_in_op == OP_WRITE || w_in_op == OP_READ)) begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = ROW_W'(w_in_row);
                end
            end
            S_CELL: begin
                w_req.wr_en   = (r_op == OP_WRITE);
                w_req.wr_addr = r_row;
            end
            S_STEP: begin
                w_req.rd_en   = (r_cnt < CNT_W'(GRID_ROWS));
                w_req.rd_addr = r_cnt[ROW_W-1:0];
                w_req.wr_en   = (r_cnt >= CNT_W'(2));
                w_req.wr_addr = w_wr_cnt[ROW_W-1:0];
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    bgas_row_mem u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_wr_row (w_wr_row),
        .o_rd_row (w_rd_row)
    );

    bgas_row_unit u_unit (
        .i_north  (r_north),
        .i_center (r_center),
        .i_south  (w_south),
        .o_row    (w_new_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= w_in_op;
                        r_row    <= ROW_W'(w_in_row);
                        r_col    <= COL_W'(w_in_col);
                        r_wv     <= w_in_wv;
                        r_cnt    <= '0;
                        r_north  <= '0;
                        r_center <= '0;
                        if (w_in_op == OP_STEP) begin
                            r_state <= S_STEP;
                        end else if (w_in_inside
                                     && (w_in_op == OP_WRITE || w_in_op == OP_READ)) begin
                            r_state <= S_CELL;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= w_in_op;
                            r_out_val   <= 1'b0;
                        end
                    end
                end
                S_CELL: begin
                    r_out_valid <= 1'b1;
                    r_out_kind  <= r_op;
                    r_out_val   <= (r_op == OP_READ) ? w_rd_row[r_col] : 1'b0;
                    r_state     <= S_IDLE;
                end
                S_STEP: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt != '0) begin
                        r_north  <= r_center;
                        r_center <= w_south;
                    end
                    if (r_cnt == CNT_W'(GRID_ROWS + 1)) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= OP_STEP;
                        r_out_val   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'(r_out_val);
    assign o_m_tuser  = r_out_kind;

`ifndef ASSERT_OFF
    a_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_cnt == CNT_W'(GRID_ROWS + 1))
        |=> (r_out_valid && r_out_kind == OP_STEP && r_state == S_IDLE))
        else $error("step did not finish with a result");

    a_cell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |=> (r_state == S_IDLE && r_out_valid))
        else $error("cell command did not finish with a result");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_out_valid || r_state != S_IDLE))
        else $error("accepted beat produced no work");

    a_wr_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.wr_en |-> ((r_state == S_CELL && r_op == OP_WRITE) || r_state == S_STEP))
        else $error("row write outside write or step");

    a_read_only_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != OP_READ) |-> !r_out_val)
        else $error("nonzero value on non-read result");
`endif

endmodule

@@ bench/binary_grid_automaton_step_test.sv @@
`timescale 1ns / 100ps

module binary_grid_automaton_step_test;

    import bgas_pkg::*;

    typedef struct packed {
        t_op  kind;
        logic value;
    } t_cell_result;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;     // col[6:0], row[13:7], write_value[14]
    logic [OP_W-1:0]     i_s_tuser  = OP_NONE; // opcode[1:0]
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;            // read_value[0]
    logic [OP_W-1:0]     o_m_tuser;            // done_kind[1:0]

    logic [GRID_COLS-1:0] grid_model [GRID_ROWS];
    t_cell_result         pending_results [$];
    int                   error_count    = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   focus_row      = 0;
    int                   focus_col      = 0;

    binary_grid_automaton_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** binary_grid_automaton_step: FAILED **");
        $finish;
    end

    // one generation over the whole grid, computed from the old grid only
    function automatic void advance_grid_model();
        logic [GRID_COLS-1:0] prev [GRID_ROWS];
        logic [GRID_COLS-1:0] north, south, east, west;
        prev = grid_model;
        for (int r = 0; r < GRID_ROWS; r++) begin
            north = (r > 0) ? prev[r-1] : '0;
            south = (r < GRID_ROWS - 1) ? prev[r+1] : '0;
            east  = prev[r] >> 1;
            west  = prev[r] << 1;
            grid_model[r] = (east | west | north) & ~(east & south & north);
        end
    endfunction

    function automatic void predict_command(t_op op, logic [COL_IN_W-1:0] col,
                                            logic [ROW_IN_W-1:0] row, logic wv);
        t_cell_result res;
        logic         on_grid;
        on_grid   = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
        res.kind  = op;
        res.value = 1'b0;
        case (op)
            OP_WRITE: begin
                if (on_grid) grid_model[row][col] = wv;
            end
            OP_READ: begin
                if (on_grid) res.value = grid_model[row][col];
            end
            OP_STEP: begin
                advance_grid_model();
            end
            default: ;
        endcase
        pending_results.push_back(res);
    endfunction

    task automatic send_command(t_op op, logic [COL_IN_W-1:0] col,
                                logic [ROW_IN_W-1:0] row, logic wv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, wv, row, col};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        predict_command(op, col, row, wv);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected beat, done_kind %0d read_value %0d",
                             $realtime, o_m_tuser, o_m_tdata[0]);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tuser !== want.kind) begin
                        $display("%0t: done_kind mismatch, expected %0d actual %0d",
                                 $realtime, want.kind, o_m_tuser);
                        error_count++;
                    end
                    if (o_m_tdata[0] !== want.value) begin
                        $display("%0t: read_value mismatch, expected %0d actual %0d",
                                 $realtime, want.value, o_m_tdata[0]);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic test_cell_access();
        send_command(OP_WRITE, 7'd0,   7'd0,   1'b1);
        send_command(OP_WRITE, 7'd127, 7'd127, 1'b1);
        send_command(OP_WRITE, 7'd127, 7'd0,   1'b1);
        send_command(OP_WRITE, 7'd0,   7'd127, 1'b1);
        send_command(OP_READ,  7'd0,   7'd0,   1'b0);
        send_command(OP_READ,  7'd127, 7'd127, 1'b1);
        send_command(OP_READ,  7'd127, 7'd0,   1'b0);
        send_command(OP_READ,  7'd1,   7'd1,   1'b0);
        send_command(OP_WRITE, 7'd127, 7'd127, 1'b0);
        send_command(OP_READ,  7'd127, 7'd127, 1'b0);
    endtask

    task automatic test_unused_opcode();
        send_command(OP_NONE, 7'd127, 7'd127, 1'b1);
        send_command(OP_NONE, 7'd0,   7'd0,   1'b0);
        send_command(OP_READ, 7'd127, 7'd127, 1'b0);
    endtask

    task automatic test_generation_edges();
        // center cell with east, west, north and south alive dies
        send_command(OP_WRITE, 7'd11, 7'd10, 1'b1);
        send_command(OP_WRITE, 7'd9,  7'd10, 1'b1);
        send_command(OP_WRITE, 7'd10, 7'd9,  1'b1);
        send_command(OP_WRITE, 7'd10, 7'd11, 1'b1);
        send_command(OP_STEP,  7'd0,  7'd0,  1'b0);
        send_command(OP_READ,  7'd10, 7'd10, 1'b0);
        send_command(OP_READ,  7'd1,  7'd0,  1'b0);
        send_command(OP_READ,  7'd0,  7'd1,  1'b0);
        send_command(OP_READ,  7'd126, 7'd0, 1'b0);
        send_command(OP_STEP,  7'd127, 7'd127, 1'b1);
        send_command(OP_READ,  7'd10, 7'd11, 1'b0);
    endtask

    task automatic pick_cell(output logic [COL_IN_W-1:0] col,
                             output logic [ROW_IN_W-1:0] row);
        if ($urandom_range(99) < 70) begin
            col = COL_IN_W'(focus_col + $urandom_range(7));
            row = ROW_IN_W'(focus_row + $urandom_range(7));
        end else begin
            col = COL_IN_W'($urandom_range(127));
            row = ROW_IN_W'($urandom_range(127));
        end
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic [COL_IN_W-1:0] col;
        logic [ROW_IN_W-1:0] row;
        int                  pick;
        t_op                 op;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(3))
                    0: focus_row = 0;
                    1: focus_row = 120;
                    default: focus_row = $urandom_range(120);
                endcase
                case ($urandom_range(3))
                    0: focus_col = 0;
                    1: focus_col = 120;
                    default: focus_col = $urandom_range(120);
                endcase
            end
            if (i == count / 2) wait_drained();
            pick = $urandom_range(99);
            if (pick < 40)      op = OP_WRITE;
            else if (pick < 80) op = OP_READ;
            else if (pick < 92) op = OP_STEP;
            else                op = OP_NONE;
            pick_cell(col, row);
            send_command(op, col, row, 1'($urandom_range(1)));
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < GRID_ROWS; r++) grid_model[r] = '0;

        test_cell_access();
        test_unused_opcode();
        test_generation_edges();
        wait_drained();
        test_random(270, 0, 0);
        test_random(270, 83, 0);
        test_random(270, 0, 83);
        test_random(270, 21, 21);

        repeat (GRID_ROWS + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** binary_grid_automaton_step: PASSED **");
        end else begin
            $display("** binary_grid_automaton_step: FAILED **");
        end
        $finish;
    end

endmodule

@@ binary_grid_automaton_step.f @@
rtl/bgas_pkg.sv
rtl/bgas_row_mem.sv
rtl/bgas_row_unit.sv
rtl/binary_grid_automaton_step.sv
bench/binary_grid_automaton_step_test.sv
